FILE: rtl/lnk_pkg.sv
// ----------------------------------------------------------------------------
// lnk_pkg
// Shared types and constants of the link level handshake block.
// ----------------------------------------------------------------------------
package lnk_pkg;

   // field and state widths
   localparam int unsigned GEN_W  = 32;
   localparam int unsigned VER_W  = 32;
   localparam int unsigned RND_W  = 32;
   localparam int unsigned BO_W   = 22;
   localparam int unsigned RT_W   = 23;
   localparam int unsigned DIV_W  = 23;
   localparam int unsigned SB_W   = 20;
   localparam int unsigned DIR_W  = 3;
   localparam int unsigned CSR_IDX_W = 2;

   // backoff grows only while below this interval
   localparam logic [BO_W-1:0] BACKOFF_LIMIT = 22'd1000000;
   localparam logic [SB_W-1:0] START_BACKOFF_RESET = 20'd100;
   localparam logic [DIR_W-1:0] LINK_DIRECTION_RESET = 3'd0;
   localparam logic [7:0] HEADER_BASE = 8'hA0;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BACKOFF  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_DIRECTION = 2'd1;

   // received packet kinds
   localparam logic [1:0] FUNC_NONE  = 2'd0;
   localparam logic [1:0] FUNC_LEVEL = 2'd1;

   typedef struct packed {
      logic [1:0]       func;
      logic [GEN_W-1:0] tile_generation;
      logic [7:0]       tile_level;
      logic [VER_W-1:0] our_version_id;
      logic [7:0]       their_level;
      logic [7:0]       their_stage;
      logic [VER_W-1:0] their_version_id;
      logic             tx_ready;
      logic [RND_W-1:0] rand_a;
      logic [RND_W-1:0] rand_b;
   } req_word_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_header;
      logic [1:0] tx_level;
      logic [1:0] tx_stage;
      logic       tx_has_version;
      logic       tx_delivered;
      logic [1:0] cur_level;
      logic [1:0] cur_stage;
      logic       incompatible;
      logic       last;
   } rsp_word_type;

   // one or two result words handed to the output buffer at once
   typedef struct packed {
      logic         push;
      logic         two;
      rsp_word_type w0;
      rsp_word_type w1;
   } push_type;

endpackage

FILE: rtl/lnk_mod_unit.sv
// ----------------------------------------------------------------------------
// lnk_mod_unit
// Shared restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lnk_mod_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lnk_pkg::RND_W-1:0] dividend,
   input  logic [lnk_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [lnk_pkg::DIV_W-1:0] remainder
);
   import lnk_pkg::*;

   localparam int unsigned CNT_W = $clog2(RND_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RND_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   // shift in the next dividend bit and subtract if it fits
   assign trial = {rem_ff, dvd_ff[RND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: rtl/lnk_rsp_buf.sv
// ----------------------------------------------------------------------------
// lnk_rsp_buf
// Two-word result buffer between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module lnk_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  lnk_pkg::push_type     push,
   output logic                  empty,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lnk_pkg::rsp_word_type rsp_word
);
   import lnk_pkg::*;

   rsp_word_type word0_ff, word0_in;
   rsp_word_type word1_ff, word1_in;
   logic [1:0]   count_ff, count_in;

   // load happens only while empty, so it never meets a pop
   always_comb begin
      word0_in = word0_ff;
      word1_in = word1_ff;
      count_in = count_ff;
      if (push.push) begin
         word0_in = push.w0;
         word1_in = push.w1;
         count_in = push.two ? 2'd2 : 2'd1;
      end else if (count_ff != 2'd0 && rsp_ready) begin
         word0_in = word1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      word0_ff <= word0_in;
      word1_ff <= word1_in;
   end

   assign empty     = count_ff == 2'd0;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_word  = word0_ff;

endmodule

FILE: rtl/lnk_core.sv
// ----------------------------------------------------------------------------
// lnk_core
// Handshake state and sequencer: decides a word, then runs the shared
// remainder unit for backoff growth and resend reload.
// ----------------------------------------------------------------------------
module lnk_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lnk_pkg::req_word_type     req_word,
   input  logic [lnk_pkg::SB_W-1:0]  start_backoff,
   input  logic [lnk_pkg::DIR_W-1:0] link_direction,
   input  logic                      buf_empty,
   output lnk_pkg::push_type         push,
   output logic                      mod_start,
   output logic [lnk_pkg::RND_W-1:0] mod_dividend,
   output logic [lnk_pkg::DIV_W-1:0] mod_divisor,
   input  logic                      mod_done,
   input  logic [lnk_pkg::DIV_W-1:0] mod_remainder
);
   import lnk_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BUMP,
      ST_LOAD,
      ST_PUSH
   } state_type;

   state_type        state_ff, state_in;
   req_word_type     item_ff, item_in;
   logic [1:0]       level_ff, level_in;
   logic [1:0]       stage_ff, stage_in;
   logic             incompat_ff, incompat_in;
   logic [BO_W-1:0]  backoff_ff, backoff_in;
   logic [RT_W-1:0]  resend_ff, resend_in;
   logic [GEN_W-1:0] seen_ff, seen_in;
   logic [1:0]       nres_ff, nres_in;
   logic [1:0]       p0l_ff, p0l_in, p0s_ff, p0s_in;
   logic [1:0]       p1l_ff, p1l_in, p1s_ff, p1s_in;
   logic             reload_ff, reload_in;
   logic             mod_start_ff, mod_start_in;
   push_type         push_ff, push_in;

   // decision of one word
   logic             gen_diff, tick_send, tick_level, digits_ok, wait_below;
   logic [1:0]       d_level, d_stage;
   logic             d_incompat, d_cfg, d_bump, d_reload, d_dec;
   logic [GEN_W-1:0] d_seen;
   logic [1:0]       d_nres, d_p0l, d_p0s, d_p1l, d_p1s;
   logic [7:0]       header;

   function automatic rsp_word_type make_word(
      input logic       valid,
      input logic [7:0] hdr,
      input logic [1:0] pl,
      input logic [1:0] ps,
      input logic       dlv,
      input logic [1:0] cl,
      input logic [1:0] cs,
      input logic       ki,
      input logic       lst
   );
      rsp_word_type w;
      w.tx_valid       = valid;
      w.tx_header      = valid ? hdr : 8'd0;
      w.tx_level       = valid ? pl : 2'd0;
      w.tx_stage       = valid ? ps : 2'd0;
      w.tx_has_version = valid && pl == 2'd0 && ps == 2'd2;
      w.tx_delivered   = valid && dlv;
      w.cur_level      = cl;
      w.cur_stage      = cs;
      w.incompatible   = ki;
      w.last           = lst;
      return w;
   endfunction

   assign gen_diff   = item_ff.tile_generation != seen_ff;
   assign tick_send  = !gen_diff && resend_ff == '0;
   assign tick_level = !gen_diff && resend_ff != '0;
   assign digits_ok  = item_ff.their_level <= 8'd3 && item_ff.their_stage <= 8'd2;
   // partner leaving the level below while we enter it: wait
   assign wait_below = level_ff != 2'd0 && item_ff.their_level == {6'd0, level_ff - 2'd1}
                       && item_ff.their_stage == 8'd2 && stage_ff == 2'd0;
   assign header     = HEADER_BASE | {5'd0, link_direction};

   // handshake decision on the latched word
   always_comb begin
      d_level    = level_ff;
      d_stage    = stage_ff;
      d_incompat = incompat_ff;
      d_seen     = seen_ff;
      d_cfg      = 1'b0;
      d_bump     = 1'b0;
      d_reload   = 1'b0;
      d_dec      = tick_level;
      d_nres     = 2'd0;
      d_p0l      = 2'd0;
      d_p0s      = 2'd0;
      d_p1l      = 2'd0;
      d_p1s      = 2'd0;
      if (gen_diff || (tick_level && item_ff.func == FUNC_NONE)) begin
         // tile change, new generation forces level zero
         if (gen_diff) begin
            d_seen = item_ff.tile_generation;
            if (level_ff != 2'd0 || stage_ff != 2'd0) begin
               d_cfg      = 1'b1;
               d_level    = 2'd0;
               d_stage    = 2'd0;
               d_incompat = 1'b0;
            end
         end
         if (d_level == 2'd0 && d_stage == 2'd1 && item_ff.tile_level != 8'd0) begin
            d_stage = 2'd2;
            d_nres  = 2'd1;
            d_p0l   = 2'd0;
            d_p0s   = 2'd2;
         end else if (d_level != 2'd0 && item_ff.tile_level == 8'd0) begin
            // step down to level zero, announcing each level
            if (d_level == 2'd2) begin
               d_nres = 2'd2;
               d_p0l  = 2'd1;
            end else begin
               d_nres = 2'd1;
               d_p0l  = 2'd0;
            end
            d_cfg      = 1'b1;
            d_level    = 2'd0;
            d_stage    = 2'd0;
            d_incompat = 1'b0;
         end
      end else if (tick_send) begin
         // resend timeout expired: announce and reload
         d_nres   = 2'd1;
         d_p0l    = level_ff;
         d_p0s    = stage_ff;
         d_bump   = !item_ff.tx_ready;
         d_reload = 1'b1;
      end else if (item_ff.func == FUNC_LEVEL && digits_ok) begin
         if (item_ff.their_level == {6'd0, level_ff}) begin
            if (stage_ff == 2'd0) begin
               d_stage = 2'd1;
               d_nres  = 2'd1;
               d_p0l   = level_ff;
               d_p0s   = 2'd1;
            end else if (stage_ff == 2'd2 && item_ff.their_stage == 8'd2 &&
                         level_ff == 2'd0 && item_ff.tile_level != 8'd0) begin
               // version check at level zero stage two
               if (item_ff.our_version_id == item_ff.their_version_id) begin
                  d_nres     = 2'd1;
                  d_p0l      = 2'd0;
                  d_p0s      = 2'd2;
                  d_cfg      = 1'b1;
                  d_level    = 2'd1;
                  d_stage    = 2'd0;
                  d_incompat = 1'b0;
               end else if (incompat_ff) begin
                  d_bump = 1'b1;
               end else begin
                  d_incompat = 1'b1;
               end
            end
         end else if (!wait_below && item_ff.their_level < {6'd0, level_ff}) begin
            // partner below us: drop to its level
            d_cfg      = 1'b1;
            d_level    = item_ff.their_level[1:0];
            d_stage    = 2'd0;
            d_incompat = 1'b0;
            d_nres     = 2'd1;
            d_p0l      = item_ff.their_level[1:0];
            d_p0s      = 2'd0;
         end else if (!wait_below) begin
            d_nres = 2'd1;
            d_p0l  = level_ff;
            d_p0s  = stage_ff;
         end
      end
   end

   // shared unit operands
   assign mod_dividend = (state_ff == ST_LOAD) ? item_ff.rand_b : item_ff.rand_a;
   assign mod_divisor  = (state_ff == ST_LOAD) ? ({1'b0, backoff_ff} + DIV_W'(1))
                                               : {backoff_ff, 1'b1};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      level_in     = level_ff;
      stage_in     = stage_ff;
      incompat_in  = incompat_ff;
      backoff_in   = backoff_ff;
      resend_in    = resend_ff;
      seen_in      = seen_ff;
      nres_in      = nres_ff;
      p0l_in       = p0l_ff;
      p0s_in       = p0s_ff;
      p1l_in       = p1l_ff;
      p1s_in       = p1s_ff;
      reload_in    = reload_ff;
      mod_start_in = 1'b0;
      push_in      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            level_in    = d_level;
            stage_in    = d_stage;
            incompat_in = d_incompat;
            seen_in     = d_seen;
            nres_in     = d_nres;
            p0l_in      = d_p0l;
            p0s_in      = d_p0s;
            p1l_in      = d_p1l;
            p1s_in      = d_p1s;
            reload_in   = d_reload;
            if (d_cfg) begin
               backoff_in = {2'd0, start_backoff};
               resend_in  = '0;
            end else if (d_dec) begin
               resend_in = resend_ff - RT_W'(1);
            end
            if (d_bump && backoff_ff < BACKOFF_LIMIT) begin
               mod_start_in = 1'b1;
               state_in     = ST_BUMP;
            end else if (d_reload) begin
               mod_start_in = 1'b1;
               state_in     = ST_LOAD;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_BUMP: begin
            // backoff grows to a draw in [b, 3b]
            if (mod_done) begin
               backoff_in = backoff_ff + BO_W'(mod_remainder);
               if (reload_ff) begin
                  mod_start_in = 1'b1;
                  state_in     = ST_LOAD;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_LOAD: begin
            // resend timeout reloads to a draw in [b, 2b]
            if (mod_done) begin
               resend_in = {1'b0, backoff_ff} + mod_remainder;
               state_in  = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (buf_empty) begin
               push_in.push = 1'b1;
               push_in.two  = nres_ff == 2'd2;
               unique case (nres_ff)
                  2'd2: begin
                     push_in.w0 = make_word(1'b1, header, p0l_ff, p0s_ff, item_ff.tx_ready,
                                            p0l_ff, p0s_ff, 1'b0, 1'b0);
                     push_in.w1 = make_word(1'b1, header, p1l_ff, p1s_ff, item_ff.tx_ready,
                                            level_ff, stage_ff, incompat_ff, 1'b1);
                  end
                  2'd1: begin
                     push_in.w0 = make_word(1'b1, header, p0l_ff, p0s_ff, item_ff.tx_ready,
                                            level_ff, stage_ff, incompat_ff, 1'b1);
                  end
                  default: begin
                     push_in.w0 = make_word(1'b0, header, 2'd0, 2'd0, 1'b0,
                                            level_ff, stage_ff, incompat_ff, 1'b1);
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= 2'd0;
         stage_ff     <= 2'd0;
         incompat_ff  <= 1'b0;
         backoff_ff   <= {2'd0, START_BACKOFF_RESET};
         resend_ff    <= '0;
         seen_ff      <= '1;
         reload_ff    <= 1'b0;
         mod_start_ff <= 1'b0;
         push_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         stage_ff     <= stage_in;
         incompat_ff  <= incompat_in;
         backoff_ff   <= backoff_in;
         resend_ff    <= resend_in;
         seen_ff      <= seen_in;
         reload_ff    <= reload_in;
         mod_start_ff <= mod_start_in;
         push_ff      <= push_in;
      end
      item_ff <= item_in;
      nres_ff <= nres_in;
      p0l_ff  <= p0l_in;
      p0s_ff  <= p0s_in;
      p1l_ff  <= p1l_in;
      p1s_ff  <= p1s_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign mod_start = mod_start_ff;
   assign push      = push_ff;

endmodule

FILE: rtl/link_level_handshake.sv
// ----------------------------------------------------------------------------
// link_level_handshake
// Per-neighbor link bring-up handshake with randomized resend backoff.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   one tick word
//   rsp      out        rsp_valid/rsp_ready   one or two result words per tick
//   csr      in         csr_valid/csr_ready   register index and write data
//
// A tick word is latched, decided, sent through the shared remainder unit
// (one dividend bit a cycle) as needed, and its results are pushed once
// the result buffer is empty: a resend tick takes one or two passes, an
// incompatible repeat at most one. req_ready is high only while the
// sequencer is idle; results wait in a two-word buffer, so the next word is
// taken while they drain. Reset is synchronous; csr writes are always taken.
// ----------------------------------------------------------------------------
module link_level_handshake (
   input  logic                          clock,
   input  logic                          reset,
   // tick words
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_func,
   input  logic [lnk_pkg::GEN_W-1:0]     req_tile_generation,
   input  logic [7:0]                    req_tile_level,
   input  logic [lnk_pkg::VER_W-1:0]     req_our_version_id,
   input  logic [7:0]                    req_their_level,
   input  logic [7:0]                    req_their_stage,
   input  logic [lnk_pkg::VER_W-1:0]     req_their_version_id,
   input  logic                          req_tx_ready,
   input  logic [lnk_pkg::RND_W-1:0]     req_rand_a,
   input  logic [lnk_pkg::RND_W-1:0]     req_rand_b,
   // result words
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_tx_valid,
   output logic [7:0]                    rsp_tx_header,
   output logic [1:0]                    rsp_tx_level,
   output logic [1:0]                    rsp_tx_stage,
   output logic                          rsp_tx_has_version,
   output logic                          rsp_tx_delivered,
   output logic [1:0]                    rsp_cur_level,
   output logic [1:0]                    rsp_cur_stage,
   output logic                          rsp_incompatible,
   output logic                          rsp_last,
   // configuration writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lnk_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lnk_pkg::SB_W-1:0]      csr_data
);
   import lnk_pkg::*;

   logic [SB_W-1:0]  start_backoff_ff, start_backoff_in;
   logic [DIR_W-1:0] link_direction_ff, link_direction_in;
   req_word_type     req_word;
   rsp_word_type     rsp_word;
   push_type         push;
   logic             buf_empty;
   logic             mod_start, mod_done;
   logic [RND_W-1:0] mod_dividend;
   logic [DIV_W-1:0] mod_divisor, mod_remainder;

   // configuration registers, unknown indexes dropped
   assign csr_ready = 1'b1;

   always_comb begin
      start_backoff_in  = start_backoff_ff;
      link_direction_in = link_direction_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_START_BACKOFF:  start_backoff_in  = csr_data;
            CSR_LINK_DIRECTION: link_direction_in = csr_data[DIR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_backoff_ff  <= START_BACKOFF_RESET;
         link_direction_ff <= LINK_DIRECTION_RESET;
      end else begin
         start_backoff_ff  <= start_backoff_in;
         link_direction_ff <= link_direction_in;
      end
   end

   // tick word packing
   always_comb begin
      req_word.func             = req_func;
      req_word.tile_generation  = req_tile_generation;
      req_word.tile_level       = req_tile_level;
      req_word.our_version_id   = req_our_version_id;
      req_word.their_level      = req_their_level;
      req_word.their_stage      = req_their_stage;
      req_word.their_version_id = req_their_version_id;
      req_word.tx_ready         = req_tx_ready;
      req_word.rand_a           = req_rand_a;
      req_word.rand_b           = req_rand_b;
   end

   lnk_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_remainder)
   );

   lnk_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .start_backoff  (start_backoff_ff),
      .link_direction (link_direction_ff),
      .buf_empty      (buf_empty),
      .push           (push),
      .mod_start      (mod_start),
      .mod_dividend   (mod_dividend),
      .mod_divisor    (mod_divisor),
      .mod_done       (mod_done),
      .mod_remainder  (mod_remainder)
   );

   lnk_rsp_buf u_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .empty     (buf_empty),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // result word unpacking
   assign rsp_tx_valid       = rsp_word.tx_valid;
   assign rsp_tx_header      = rsp_word.tx_header;
   assign rsp_tx_level       = rsp_word.tx_level;
   assign rsp_tx_stage       = rsp_word.tx_stage;
   assign rsp_tx_has_version = rsp_word.tx_has_version;
   assign rsp_tx_delivered   = rsp_word.tx_delivered;
   assign rsp_cur_level      = rsp_word.cur_level;
   assign rsp_cur_stage      = rsp_word.cur_stage;
   assign rsp_incompatible   = rsp_word.incompatible;
   assign rsp_last           = rsp_word.last;

endmodule

FILE: rtl/lnk_port_check.sv
// ----------------------------------------------------------------------------
// lnk_port_check
// Port-level checks of the link level handshake, bound to the top level.
// ----------------------------------------------------------------------------
module lnk_port_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_tx_valid,
   input logic [7:0]                    rsp_tx_header,
   input logic [1:0]                    rsp_tx_level,
   input logic [1:0]                    rsp_tx_stage,
   input logic                          rsp_tx_has_version,
   input logic                          rsp_tx_delivered,
   input logic [1:0]                    rsp_cur_level,
   input logic [1:0]                    rsp_cur_stage,
   input logic                          rsp_incompatible,
   input logic                          rsp_last
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_valid) &&
      $stable(rsp_tx_header) && $stable(rsp_tx_level) && $stable(rsp_tx_stage) &&
      $stable(rsp_tx_has_version) && $stable(rsp_tx_delivered) &&
      $stable(rsp_cur_level) && $stable(rsp_cur_stage) && $stable(rsp_incompatible) &&
      $stable(rsp_last))
      else $error("stalled result word changed");

   // one tick word at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second tick word taken while busy");

   // announce header carries the fixed tag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_valid |-> rsp_tx_header[7:3] == 5'b10100)
      else $error("announce header tag wrong");

   // version payload only on a level zero stage two announce
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_has_version |->
      rsp_tx_valid && rsp_tx_level == 2'd0 && rsp_tx_stage == 2'd2)
      else $error("version payload on wrong announce");

   // status never reaches level or stage three
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_level != 2'd3 && rsp_cur_stage != 2'd3)
      else $error("status out of range");

endmodule

bind link_level_handshake lnk_port_check u_port_check (.*);
